>>> design/go_to_goal_controller_defines.svh
// ----------------------------------------------------------------------------
// Go-to-goal controller assertion macros
// Shared assertion forms for the controller RTL, clocked on clk_i with
// rst_ni as the disable.
// ----------------------------------------------------------------------------
`ifndef GO_TO_GOAL_CONTROLLER_DEFINES_SVH
`define GO_TO_GOAL_CONTROLLER_DEFINES_SVH

// same-cycle implication
`define G2G_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define G2G_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/g2g_pkg.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller package
// Widths, arctangent table, register indexes and the pipeline stage payload.
// ----------------------------------------------------------------------------
package g2g_pkg;

  localparam int unsigned CORDIC_STAGES_DEF = 16;
  localparam int unsigned CORDIC_MAX        = 24;
  localparam int unsigned SQRT_STEPS        = 17;

  localparam int unsigned XY_W   = 28;
  localparam int unsigned Z_W    = 25;
  localparam int unsigned RAD_W  = 34;
  localparam int unsigned REM_W  = 20;
  localparam int unsigned ROOT_W = 17;
  localparam int unsigned POS_W  = 16;
  localparam int unsigned TH_W   = 15;
  localparam int unsigned GAIN_W = 8;
  localparam int unsigned LIN_W  = 17;
  localparam int unsigned ANG_W  = 24;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic signed [Z_W-1:0] HALF_PI_Z = 25'sd1647099;

  localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_MAX] = '{
    25'sd823550, 25'sd486170, 25'sd256879, 25'sd130396,
    25'sd65451,  25'sd32757,  25'sd16383,  25'sd8192,
    25'sd4096,   25'sd2048,   25'sd1024,   25'sd512,
    25'sd256,    25'sd128,    25'sd64,     25'sd32,
    25'sd16,     25'sd8,      25'sd4,      25'sd2,
    25'sd1,      25'sd0,      25'sd0,      25'sd0
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_X         = 3'd0,
    CFG_GOAL_Y         = 3'd1,
    CFG_LINEAR_GAIN    = 3'd2,
    CFG_ANGULAR_GAIN   = 3'd3,
    CFG_STOP_TOLERANCE = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [RAD_W-1:0]       rad;
    logic [REM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    logic signed [TH_W-1:0] theta;
  } stage_t;

endpackage

>>> design/g2g_step.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller pipeline step
// One registered step: a vectoring CORDIC rotation and one root bit of the
// digit-by-digit square root, each active only over its own step count.
// ----------------------------------------------------------------------------
module g2g_step #(
  parameter int unsigned IDX           = 0,
  parameter int unsigned CORDIC_STAGES = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic            valid_i,
  input  g2g_pkg::stage_t stage_i,
  output logic            valid_o,
  output g2g_pkg::stage_t stage_o
);
  import g2g_pkg::*;

  stage_t stage_d;
  stage_t stage_q;
  logic   valid_q;

  always_comb begin
    stage_d = stage_i;
    if (IDX < CORDIC_STAGES && IDX < CORDIC_MAX) begin
      if (stage_i.y > 0) begin
        stage_d.x = stage_i.x + (stage_i.y >>> IDX);
        stage_d.y = stage_i.y - (stage_i.x >>> IDX);
        stage_d.z = stage_i.z + ATAN_TAB[IDX];
      end else begin
        stage_d.x = stage_i.x - (stage_i.y >>> IDX);
        stage_d.y = stage_i.y + (stage_i.x >>> IDX);
        stage_d.z = stage_i.z - ATAN_TAB[IDX];
      end
    end
  end

  generate
    if (IDX < SQRT_STEPS) begin : g_sqrt
      localparam int unsigned J = SQRT_STEPS - 1 - IDX;
      logic [REM_W-1:0] rem_sh;
      logic [REM_W-1:0] trial;
      stage_t           stage_s;
      always_comb begin
        rem_sh  = {stage_i.rem[REM_W-3:0], stage_i.rad[2*J+1 -: 2]};
        trial   = {1'b0, stage_i.root, 2'b01};
        stage_s = stage_d;
        if (rem_sh >= trial) begin
          stage_s.rem  = rem_sh - trial;
          stage_s.root = {stage_i.root[ROOT_W-2:0], 1'b1};
        end else begin
          stage_s.rem  = rem_sh;
          stage_s.root = {stage_i.root[ROOT_W-2:0], 1'b0};
        end
      end
      always_comb begin
        stage_o = stage_q;
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          stage_q <= stage_s;
        end
      end
    end else begin : g_pass
      always_comb begin
        stage_o = stage_q;
      end
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          stage_q <= stage_d;
        end
      end
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  assign valid_o = valid_q;

endmodule

>>> design/go_to_goal_controller.sv
// ----------------------------------------------------------------------------
// Go-to-goal controller
// Proportional controller: distance and bearing to a configured goal from
// each pose request, turned into forward speed and turn rate commands.
//
//   channel  direction  handshake                 payload
//   pose     in         in_valid_i / in_stall_o   pose_x_i, pose_y_i, pose_theta_i
//   command  out        out_valid_o / out_stall_i linear_velocity_o,
//                                                 angular_velocity_o, arrived_o
//   config   in         cfg_we_i                  cfg_idx_i, cfg_wdata_i
//
// One request enters per cycle while in_stall_o is low; the pipeline depth is
// set by the root-bit steps of the square root or the CORDIC rotations.
// Every stage carries a valid bit; a stage takes new data when it is empty
// or its content moves on, so bubbles close up under an output stall.
// Reset clears all valid bits and loads the register reset values.
// ----------------------------------------------------------------------------
`include "go_to_goal_controller_defines.svh"

module go_to_goal_controller #(
  parameter int unsigned CORDIC_STAGES = g2g_pkg::CORDIC_STAGES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [g2g_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [g2g_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [g2g_pkg::POS_W-1:0]    pose_x_i,
  input  logic signed [g2g_pkg::POS_W-1:0]    pose_y_i,
  input  logic signed [g2g_pkg::TH_W-1:0]     pose_theta_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [g2g_pkg::LIN_W-1:0]           linear_velocity_o,
  output logic signed [g2g_pkg::ANG_W-1:0]    angular_velocity_o,
  output logic                                arrived_o
);
  import g2g_pkg::*;

  localparam int unsigned N = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;
  localparam int unsigned L = N + 6;

  logic signed [POS_W-1:0]  goal_x_q, goal_y_q;
  logic [GAIN_W-1:0]        linear_gain_q, angular_gain_q;
  logic [POS_W-1:0]         stop_tolerance_q;

  logic [L-1:0] v_all;
  logic [L:0]   en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      goal_x_q         <= '0;
      goal_y_q         <= '0;
      linear_gain_q    <= 8'd128;
      angular_gain_q   <= 8'd64;
      stop_tolerance_q <= 16'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_GOAL_X:         goal_x_q         <= cfg_wdata_i;
        CFG_GOAL_Y:         goal_y_q         <= cfg_wdata_i;
        CFG_LINEAR_GAIN:    linear_gain_q    <= cfg_wdata_i[GAIN_W-1:0];
        CFG_ANGULAR_GAIN:   angular_gain_q   <= cfg_wdata_i[GAIN_W-1:0];
        CFG_STOP_TOLERANCE: stop_tolerance_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // stall chain
  assign en[L] = !out_stall_i;
  generate
    for (genvar i = 0; i < L; i++) begin : g_en
      assign en[i] = !v_all[i] || en[i+1];
    end
  endgenerate

  assign in_stall_o = !en[0];

  logic [L-1:0] v_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
      if (en[N+3]) v_q[N+3] <= v_all[N+2];
      if (en[N+4]) v_q[N+4] <= v_q[N+3];
      if (en[N+5]) v_q[N+5] <= v_q[N+4];
    end
  end

  assign v_all[2:0]     = v_q[2:0];
  assign v_all[L-1:N+3] = v_q[L-1:N+3];

  // stage 0: offsets
  logic signed [POS_W:0]  dx_q, dy_q;
  logic signed [TH_W-1:0] th0_q;
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      dx_q  <= {goal_x_q[POS_W-1], goal_x_q} - {pose_x_i[POS_W-1], pose_x_i};
      dy_q  <= {goal_y_q[POS_W-1], goal_y_q} - {pose_y_i[POS_W-1], pose_y_i};
      th0_q <= pose_theta_i;
    end
  end

  // stage 1: squares and quadrant pre-rotation
  logic signed [RAD_W-1:0] sqx_d, sqy_d, sqx_q, sqy_q;
  logic signed [XY_W-1:0]  xt, yt, x1_d, y1_d, x1_q, y1_q;
  logic signed [Z_W-1:0]   z1_d, z1_q;
  logic signed [TH_W-1:0]  th1_q;

  always_comb begin
    sqx_d = RAD_W'(dx_q) * RAD_W'(dx_q);
    sqy_d = RAD_W'(dy_q) * RAD_W'(dy_q);
    xt    = {{(XY_W-POS_W-9){dx_q[POS_W]}}, dx_q, 8'b0};
    yt    = {{(XY_W-POS_W-9){dy_q[POS_W]}}, dy_q, 8'b0};
    x1_d  = xt;
    y1_d  = yt;
    z1_d  = '0;
    if (dx_q < 0) begin
      if (dy_q >= 0) begin
        x1_d = yt;
        y1_d = -xt;
        z1_d = HALF_PI_Z;
      end else begin
        x1_d = -yt;
        y1_d = xt;
        z1_d = -HALF_PI_Z;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      sqx_q <= sqx_d;
      sqy_q <= sqy_d;
      x1_q  <= x1_d;
      y1_q  <= y1_d;
      z1_q  <= z1_d;
      th1_q <= th0_q;
    end
  end

  // stage 2: radicand
  stage_t st [N+1];
  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      st[0].x     <= x1_q;
      st[0].y     <= y1_q;
      st[0].z     <= z1_q;
      st[0].rad   <= $unsigned(sqx_q) + $unsigned(sqy_q);
      st[0].rem   <= '0;
      st[0].root  <= '0;
      st[0].theta <= th1_q;
    end
  end

  generate
    for (genvar k = 0; k < N; k++) begin : g_step
      g2g_step #(
        .IDX          (k),
        .CORDIC_STAGES(CORDIC_STAGES)
      ) u_step (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (en[k+3]),
        .valid_i(v_all[k+2]),
        .stage_i(st[k]),
        .valid_o(v_all[k+3]),
        .stage_o(st[k+1])
      );
    end
  endgenerate

  // final 1: bearing, heading error, arrival, linear product
  logic signed [Z_W-1:0]      zr;
  logic signed [Z_W-9:0]      bear;
  logic signed [Z_W-8:0]      err_q;
  logic                       arr1_q, arr2_q;
  logic [GAIN_W+ROOT_W-1:0]   lprod_q;

  always_comb begin
    zr   = st[N].z + 25'sd128;
    bear = zr[Z_W-1:8];
  end

  always_ff @(posedge clk_i) begin
    if (en[N+3]) begin
      err_q   <= {bear[Z_W-9], bear} - {{(Z_W-7-TH_W){st[N].theta[TH_W-1]}}, st[N].theta};
      arr1_q  <= (st[N].root <= {1'b0, stop_tolerance_q});
      lprod_q <= (GAIN_W+ROOT_W)'(linear_gain_q) * (GAIN_W+ROOT_W)'(st[N].root);
    end
  end

  // final 2: angular product, linear rounding
  logic signed [Z_W+1:0]    aprod_q;
  logic [GAIN_W+ROOT_W-1:0] lsum;
  logic [LIN_W-1:0]         lin2_q;

  assign lsum = lprod_q + 25'd128;

  always_ff @(posedge clk_i) begin
    if (en[N+4]) begin
      aprod_q <= (Z_W+2)'(err_q) * (Z_W+2)'($signed({1'b0, angular_gain_q}));
      lin2_q  <= lsum[GAIN_W+ROOT_W-1:8];
      arr2_q  <= arr1_q;
    end
  end

  // final 3: angular rounding, output register
  logic signed [Z_W+2:0] asum;
  logic [LIN_W-1:0]      lin_q;
  logic signed [ANG_W-1:0] ang_q;
  logic                  arr_q;

  assign asum = {aprod_q[Z_W+1], aprod_q} + 28'sd8;

  always_ff @(posedge clk_i) begin
    if (en[N+5]) begin
      arr_q <= arr2_q;
      lin_q <= arr2_q ? '0 : lin2_q;
      ang_q <= arr2_q ? '0 : asum[Z_W+2:4];
    end
  end

  assign out_valid_o        = v_q[L-1];
  assign linear_velocity_o  = lin_q;
  assign angular_velocity_o = ang_q;
  assign arrived_o          = arr_q;

  `G2G_ASSERT_NOW(a_arrived_zero, out_valid_o && arrived_o,
    linear_velocity_o == '0 && angular_velocity_o == '0, "arrived with nonzero command")
  `G2G_ASSERT_NOW(a_no_input_stall, !out_valid_o || !out_stall_i, !in_stall_o,
    "input stalled while output drains")
  `G2G_ASSERT_NOW(a_stall_full, in_stall_o, v_q[0] && out_valid_o && out_stall_i,
    "input stalled with a free stage")
  `G2G_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && arrived_o == $past(arrived_o), "stalled result lost")

endmodule
